// ===== sv/kdpd_pkg.sv =====
package kdpd_pkg;

    // Fixed field widths.
    localparam int RAW_WIDTH   = 4;
    localparam int TIME_WIDTH  = 32;
    localparam int EVENT_WIDTH = 2;
    localparam int CFG_INDEX_WIDTH = 2;

    // Default number of keys and the hold time loaded at reset.
    localparam int NUM_KEYS_DEF = 4;
    localparam logic [TIME_WIDTH-1:0] HOLD_RESET = 32'd20000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISE_HOLD = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FALL_HOLD = 2'd1;

    // Event codes.
    localparam logic [EVENT_WIDTH-1:0] EVT_NONE     = 2'd0;
    localparam logic [EVENT_WIDTH-1:0] EVT_CH_PLUS  = 2'd1;
    localparam logic [EVENT_WIDTH-1:0] EVT_POWER    = 2'd2;
    localparam logic [EVENT_WIDTH-1:0] EVT_CH_MINUS = 2'd3;

    typedef struct packed {
        logic [RAW_WIDTH-1:0]  raw_keys;
        logic [TIME_WIDTH-1:0] now_time;
    } sample_item_t;

    typedef struct packed {
        logic [EVENT_WIDTH-1:0] key_event;
        logic [RAW_WIDTH-1:0]   clean_keys;
    } result_item_t;

    // What one key lane reports to the merging stage.
    typedef struct packed {
        logic clean;
        logic new_press;
    } lane_status_t;

    // Event code raised by a new press of the given key.
    function automatic logic [EVENT_WIDTH-1:0] key_event_code(input int key);
        logic [EVENT_WIDTH-1:0] code;
        case (key)
            0:       code = EVT_CH_PLUS;
            1:       code = EVT_POWER;
            2:       code = EVT_CH_MINUS;
            default: code = EVT_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/kdpd_lane.sv =====
module kdpd_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                enable,
    input  logic                                level,
    input  logic [kdpd_pkg::TIME_WIDTH-1:0]     now_time,
    input  logic [kdpd_pkg::TIME_WIDTH-1:0]     rise_hold,
    input  logic [kdpd_pkg::TIME_WIDTH-1:0]     fall_hold,
    output kdpd_pkg::lane_status_t              status
);
    import kdpd_pkg::*;

    logic                  clean_reg, clean_next;
    logic                  timer_reg, timer_next;
    logic                  latch_reg, latch_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;

    logic                  differ;
    logic [TIME_WIDTH-1:0] hold;
    logic [TIME_WIDTH-1:0] start_eff;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  done;

    // A timer that is not yet running starts at the current time stamp.
    assign differ    = level != clean_reg;
    assign hold      = level ? rise_hold : fall_hold;
    assign start_eff = timer_reg ? start_reg : now_time;
    assign elapsed   = now_time - start_eff;
    assign done      = elapsed >= hold;

    always_comb
    begin
        clean_next = clean_reg;
        timer_next = 1'b0;
        start_next = start_reg;
        if (differ)
        begin
            start_next = start_eff;
            timer_next = !done;
            if (done)
            begin
                clean_next = level;
            end
        end
        // The latch follows the clean level: set on a press, cleared on a release.
        latch_next = clean_next;
    end

    assign status.clean     = clean_next;
    assign status.new_press = clean_next && !latch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clean_reg <= 1'b0;
            timer_reg <= 1'b0;
            latch_reg <= 1'b0;
            start_reg <= '0;
        end
        else if (enable)
        begin
            clean_reg <= clean_next;
            timer_reg <= timer_next;
            latch_reg <= latch_next;
            start_reg <= start_next;
        end
    end

    // The latch only ever copies the clean level, so the two never part.
    assert property (@(posedge clk) disable iff (!rst_n) latch_reg == clean_reg)
        else $error("press latch out of step with clean level");

endmodule

// ===== sv/kdpd_merge.sv =====
module kdpd_merge #(
    parameter int NUM_KEYS = kdpd_pkg::NUM_KEYS_DEF
) (
    input  kdpd_pkg::lane_status_t [NUM_KEYS-1:0] lanes,
    output kdpd_pkg::result_item_t                result
);
    import kdpd_pkg::*;

    // Keys are scanned upwards, so the highest new press decides the event.
    always_comb
    begin
        result.key_event  = EVT_NONE;
        result.clean_keys = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (lanes[k].new_press)
            begin
                result.key_event = key_event_code(k);
            end
            if (k < RAW_WIDTH)
            begin
                result.clean_keys[k] = lanes[k].clean;
            end
        end
    end

endmodule

// ===== sv/keypad_debounce_press_detect.sv =====
// Timed debounce of a small keypad with press-edge detection.
//
// The sample channel (sample_valid, sample_stall, sample) carries one
// transaction per key scan: four raw key levels and a free-running 32-bit
// time stamp. Every key has its own lane that times a level change against
// the rise or fall hold time; a merging stage turns new presses into an
// event code and collects the clean levels. The result channel (result_valid,
// result_stall, result) returns exactly one transaction per sample.
//
// A sample is taken every cycle while the result side keeps up; the result
// is registered in the output stage. The per-key lane does its wrapping
// subtract and compare combinationally as the sample is accepted. A two-entry
// output stage means that a sample is still accepted while one result waits;
// only when both entries hold results does sample_stall rise.
//
// The configuration port writes the rise (index 0) and fall (index 1) hold
// times; other indexes are ignored. It is always ready. Reset loads both
// hold times with 20000, releases every key and empties the output stage.
module keypad_debounce_press_detect #(
    parameter int NUM_KEYS = kdpd_pkg::NUM_KEYS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  kdpd_pkg::sample_item_t                  sample,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output kdpd_pkg::result_item_t                  result,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [kdpd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [kdpd_pkg::TIME_WIDTH-1:0]         cfg_data
);
    import kdpd_pkg::*;

    logic [TIME_WIDTH-1:0] rise_hold_reg;
    logic [TIME_WIDTH-1:0] fall_hold_reg;

    lane_status_t [NUM_KEYS-1:0] lane_status;
    result_item_t                merged;

    result_item_t out_data_reg, out_data_next;
    logic         out_valid_reg, out_valid_next;
    result_item_t skid_data_reg, skid_data_next;
    logic         skid_valid_reg, skid_valid_next;

    logic sample_fire;
    logic result_fire;

    // The configuration registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_hold_reg <= HOLD_RESET;
            fall_hold_reg <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RISE_HOLD: rise_hold_reg <= cfg_data;
                REG_FALL_HOLD: fall_hold_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // A sample is refused only when the skid entry is occupied, which is a
    // registered condition and therefore independent of sample_valid.
    assign sample_stall = skid_valid_reg;
    assign sample_fire  = sample_valid && !sample_stall;
    assign result_fire  = out_valid_reg && !result_stall;

    // One lane per key. Keys beyond the raw field always see a released level.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic level;
        if (k < RAW_WIDTH)
        begin : g_raw
            assign level = sample.raw_keys[k];
        end
        else
        begin : g_none
            assign level = 1'b0;
        end

        kdpd_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (sample_fire),
            .level     (level),
            .now_time  (sample.now_time),
            .rise_hold (rise_hold_reg),
            .fall_hold (fall_hold_reg),
            .status    (lane_status[k])
        );
    end

    kdpd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .lanes  (lane_status),
        .result (merged)
    );

    // Two-entry output stage. The head entry drives the result port; the skid
    // entry catches a new result while the head is held by the receiver.
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || result_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = merged;
                out_valid_next = sample_fire;
            end
        end
        else if (sample_fire)
        begin
            skid_data_next  = merged;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // The skid entry is only ever filled behind a waiting head entry.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the head is empty");

    // An accepted sample always leaves a result on the port in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) sample_fire |=> result_valid)
        else $error("accepted sample produced no result");

    // A channel-plus event can only come from key 0 being cleanly pressed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.key_event == EVT_CH_PLUS) |-> result.clean_keys[0])
        else $error("channel-plus event without key 0 pressed");

endmodule

// ===== tb/debounce_checker.sv =====
`timescale 1ns / 100ps

// Watches the sample, result and register channels of the keypad debouncer,
// keeps its own copy of the per-key debounce state and compares every result
// transaction with the oldest prediction.
module debounce_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    input  logic                                 sample_stall,
    input  kdpd_pkg::sample_item_t               sample,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  kdpd_pkg::result_item_t               result,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [kdpd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [kdpd_pkg::TIME_WIDTH-1:0]      cfg_data,
    output int                                   fail_count,
    output int                                   pending_results
);
    import kdpd_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int CODED_KEYS = 3;
    // Press codes of keys 0 to 2, key 0 in the lowest bits.
    localparam logic [CODED_KEYS*EVENT_WIDTH-1:0] PRESS_CODES =
        {EVT_CH_MINUS, EVT_POWER, EVT_CH_PLUS};

    logic [TIME_WIDTH-1:0] rise_hold;
    logic [TIME_WIDTH-1:0] fall_hold;
    logic                  clean_lvl   [NUM_KEYS_DEF];
    logic                  timing      [NUM_KEYS_DEF];
    logic [TIME_WIDTH-1:0] start_stamp [NUM_KEYS_DEF];
    logic                  latched     [NUM_KEYS_DEF];
    result_item_t          expected_results [$];
    int                    mismatch_count = 0;

    // Leftover predictions count as failures too; the top reads this only
    // once the channels have gone quiet.
    assign fail_count = mismatch_count + pending_results;

    // Advances the debounce state by one key scan and returns its result.
    function automatic result_item_t debounce_step(input sample_item_t s);
        result_item_t          r;
        logic                  level;
        logic [TIME_WIDTH-1:0] hold;
        logic [TIME_WIDTH-1:0] elapsed;
        int                    k;
        r.key_event = EVT_NONE;
        r.clean_keys = '0;
        for (k = 0; k < NUM_KEYS_DEF; k++)
        begin
            level = (k < RAW_WIDTH) ? s.raw_keys[k] : 1'b0;
            if (level != clean_lvl[k])
            begin
                hold = level ? rise_hold : fall_hold;
                if (!timing[k])
                begin
                    timing[k] = 1'b1;
                    start_stamp[k] = s.now_time;
                end
                // Elapsed time wraps with the time stamp.
                elapsed = s.now_time - start_stamp[k];
                if (elapsed >= hold)
                begin
                    clean_lvl[k] = level;
                    timing[k] = 1'b0;
                end
            end
            else
                timing[k] = 1'b0;
            if (clean_lvl[k])
            begin
                if (!latched[k])
                begin
                    // Later keys overwrite, and keys without a code clear it.
                    latched[k] = 1'b1;
                    r.key_event = (k < CODED_KEYS) ?
                        PRESS_CODES[k*EVENT_WIDTH +: EVENT_WIDTH] : EVT_NONE;
                end
            end
            else
                latched[k] = 1'b0;
            if (k < RAW_WIDTH)
                r.clean_keys[k] = clean_lvl[k];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_item_t predicted;
        result_item_t oldest;
        int           k;
        if (!rst_n)
        begin
            rise_hold = HOLD_RESET;
            fall_hold = HOLD_RESET;
            for (k = 0; k < NUM_KEYS_DEF; k++)
            begin
                clean_lvl[k] = 1'b0;
                timing[k] = 1'b0;
                start_stamp[k] = '0;
                latched[k] = 1'b0;
            end
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RISE_HOLD)
                    rise_hold = cfg_data;
                else if (cfg_index == REG_FALL_HOLD)
                    fall_hold = cfg_data;
            end
            if (sample_valid && !sample_stall)
            begin
                predicted = debounce_step(sample);
                expected_results.push_back(predicted);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result transaction, event %0d clean %b",
                                 $time, result.key_event, result.clean_keys);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.key_event !== oldest.key_event ||
                        result.clean_keys !== oldest.clean_keys)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected event %0d clean %b, got event %0d clean %b",
                                     $time, oldest.key_event, oldest.clean_keys,
                                     result.key_event, result.clean_keys);
                    end
                end
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Top level of the keypad debouncer testbench. It generates the key scans,
// the register writes and the back-pressure on the result side; a separate
// checker beside the block predicts and compares every result transaction
// and hands back a failure count, from which this module gives the verdict.
module tb;
    import kdpd_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 125;
    localparam int MAX_IDLE = 18;
    // The block decodes two register indexes only; these two must be ignored.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;

    // Every input of the block starts from a known value.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    sample_item_t               sample = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    result_item_t               result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_RISE_HOLD;
    logic [TIME_WIDTH-1:0]      cfg_data = '0;

    int                         fail_count;
    int                         pending_results;
    int                         cycle_count = 0;
    logic [TIME_WIDTH-1:0]      stamp = '0;
    bit                         fast_feed = 1'b0;
    bit                         calm_rx = 1'b0;
    int unsigned                calm_left = 0;
    int unsigned                stall_left = 0;

    always #5 clk = ~clk;

    keypad_debounce_press_detect DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    debounce_checker debounce_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Result side: after each accepted transaction the receiver stalls for a
    // freshly drawn number of cycles. Now and then it switches into a calm
    // stretch in which it never stalls, so that the block also sees full rate.
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned draw;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (result_valid && !result_stall)
        begin
            if (calm_left == 0)
            begin
                calm_rx = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(10, 40);
            end
            else
                calm_left--;
            draw = calm_rx ? 0 : $urandom_range(0, MAX_IDLE);
            stall_left <= draw;
            result_stall <= (draw != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= (stall_left > 1);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL keypad_debounce_press_detect");
            $finish;
        end
    end

    // Offers one key scan and returns at the edge where it is accepted. The
    // valid is only lowered when an idle gap is drawn, so back-to-back
    // transactions keep it high without a glitch.
    task automatic send_sample(input logic [RAW_WIDTH-1:0] keys,
                               input logic [TIME_WIDTH-1:0] scan_time);
        int unsigned  gap;
        sample_item_t item;
        gap = fast_feed ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.raw_keys = keys;
        item.now_time = scan_time;
        sample_valid <= 1'b1;
        sample <= item;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result has come back.
    // The extra edge lets the checker record the last accepted scan first.
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    // Leaves the write valid high; the caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] reg_index,
                             input logic [TIME_WIDTH-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Hold times are changed only with the block idle. Every change also
    // writes junk to an undecoded index, which must leave both registers alone.
    task automatic configure(input logic [TIME_WIDTH-1:0] rise,
                             input logic [TIME_WIDTH-1:0] fall);
        drain_results();
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        write_reg(REG_RISE_HOLD, rise);
        write_reg(REG_FALL_HOLD, fall);
        cfg_valid <= 1'b0;
    endtask

    // One random phase under a given pair of hold times. The scans follow a
    // key pattern that stays put for several samples, so that many changes
    // survive their hold time, with contact bounce flipping single keys and
    // the odd wild time stamp as noise. Time advances per scan by up to half the
    // longer hold plus one, so most steady changes are accepted after a few scans.
    task automatic run_phase(input logic [TIME_WIDTH-1:0] rise,
                             input logic [TIME_WIDTH-1:0] fall);
        logic [RAW_WIDTH-1:0]  target;
        logic [RAW_WIDTH-1:0]  keys;
        logic [TIME_WIDTH-1:0] longest;
        logic [TIME_WIDTH-1:0] stride;
        int unsigned           bit_pick;
        int                    n;
        configure(rise, fall);
        longest = (rise > fall) ? rise : fall;
        stride = longest / 2 + 1;
        target = RAW_WIDTH'($urandom_range(0, 15));
        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            if (n % 30 == 0)
                fast_feed = ($urandom_range(0, 3) == 0);
            // Halfway through, the sender waits for the block to empty.
            if (n == PHASE_ITEMS / 2)
                drain_results();
            if ($urandom_range(0, 7) == 0)
                target = RAW_WIDTH'($urandom_range(0, 15));
            keys = target;
            if ($urandom_range(0, 3) == 0)
            begin
                bit_pick = $urandom_range(0, RAW_WIDTH - 1);
                keys[bit_pick] = ~keys[bit_pick];
            end
            if ($urandom_range(0, 19) == 0)
                stamp = $urandom;
            else
                stamp = stamp + $urandom_range(0, stride);
            send_sample(keys, stamp);
        end
        fast_feed = 1'b0;
    endtask

    initial
    begin
        logic [TIME_WIDTH-1:0] near_wrap;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset hold times. All four keys are pressed
        // just before the time stamp wraps and accepted exactly one hold time
        // later across the wrap; key 3 is handled last and leaves no event.
        near_wrap = 32'hFFFF_FFFF - 32'd5000;
        send_sample(4'h0, 32'd0);
        send_sample(4'hF, near_wrap);
        send_sample(4'hF, near_wrap + HOLD_RESET);
        // Releases: keys 1 and 2 bounce back, which cancels their timers,
        // while keys 0 and 3 complete their release one hold time on.
        send_sample(4'h0, 32'd15000);
        send_sample(4'h6, 32'd20000);
        send_sample(4'h0, 32'd35000);
        send_sample(4'h0, 32'd55000);
        // Keys 0 and 1 pressed together: one short of the hold, then exactly
        // on it, where the higher key's code wins.
        send_sample(4'h3, 32'd60000);
        send_sample(4'h3, 32'd79999);
        send_sample(4'h3, 32'd80000);
        // Key 1 released while key 2 goes down on its own.
        send_sample(4'h1, 32'd80001);
        send_sample(4'h5, 32'd100001);
        send_sample(4'h5, 32'd120001);

        // Zero hold times: every change is taken in the scan that shows it.
        configure(32'd0, 32'd0);
        send_sample(4'h8, 32'd120002);
        send_sample(4'h0, 32'd120002);
        send_sample(4'h1, 32'd7);
        send_sample(4'h7, 32'd7);

        // Largest hold times: only an elapsed time of all ones is enough,
        // which a stamp one below the start gives through the wrap.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(4'h8, 32'd1000);
        send_sample(4'h8, 32'd999);
        send_sample(4'h0, 32'hFFFF_FFFF);
        send_sample(4'h0, 32'hFFFF_FFFE);

        // Random phases with short, zero, reset, random, extreme and medium hold times.
        stamp = $urandom;
        run_phase(TIME_WIDTH'($urandom_range(1, 40)), TIME_WIDTH'($urandom_range(1, 40)));
        run_phase(32'd0, TIME_WIDTH'($urandom_range(1, 500)));
        run_phase(HOLD_RESET, HOLD_RESET);
        run_phase($urandom, $urandom);
        run_phase(32'hFFFF_FFFF, 32'd0);
        run_phase(TIME_WIDTH'($urandom_range(100, 5000)),
                  TIME_WIDTH'($urandom_range(100, 5000)));

        // Let everything come back and give stray results a chance to appear first.
        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("PASS keypad_debounce_press_detect");
        else
            $display("FAIL keypad_debounce_press_detect");
        $finish;
    end

endmodule
